// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the pointer trail RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define PTL_ASSERT_HOLD(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ptl: invariant violated");

// antecedent implies consequent in the same cycle
`define PTL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptl: same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define PTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptl: next-cycle implication violated");

`endif

// ===== rtl/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptl_pkg
// Types, constants and helpers for the pointer trail motion and loop test.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

   localparam int TRAIL_DEPTH_DEF = 64;
   localparam int COORD_W         = 16;
   localparam int DIFF_W          = 17;
   localparam int LEN_W           = 21;
   localparam int HEAD_W          = 15;
   localparam int ANGLE_W         = 16;
   localparam int TOTAL_W         = 17;
   localparam int SQ_W            = 34;
   localparam int ROOT_W          = 43;
   localparam int CORDIC_W        = 36;
   localparam int Z_W             = 24;
   localparam int CORDIC_STEPS    = 16;
   localparam int STEP_W          = 4;
   localparam int PRESCALE        = 14;

   localparam logic signed [TOTAL_W-1:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [TOTAL_W-1:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd5760;
   localparam logic signed [Z_W-1:0]     Z_HALF_TURN  = 24'sd737280;

   // arctan(2^-i) in 1/4096 degree
   localparam logic [17:0] ATAN_TAB [CORDIC_STEPS] = '{
      18'd184320, 18'd108810, 18'd57492, 18'd29184, 18'd14649, 18'd7331,
      18'd3667,   18'd1833,   18'd917,   18'd458,   18'd229,   18'd115,
      18'd57,     18'd29,     18'd14,    18'd7
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_LOAD,
      ST_A_SQX,
      ST_A_SQY,
      ST_A_ROOT,
      ST_Q_FIRST,
      ST_Q_FWAIT,
      ST_Q_CHECK,
      ST_Q_LOAD,
      ST_Q_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                      start;
      logic signed [DIFF_W-1:0]  x;
      logic signed [DIFF_W-1:0]  y;
   } cordic_req_type;

   typedef struct packed {
      logic                      busy;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_rsp_type;

   // signed angle step from a1 to a2, wrapped into one half turn each way
   function automatic logic signed [ANGLE_W-1:0] wrap_delta(
      input logic signed [ANGLE_W-1:0] a1,
      input logic signed [ANGLE_W-1:0] a2
   );
      logic signed [TOTAL_W-1:0] d;
      d = TOTAL_W'(a2) - TOTAL_W'(a1);
      if (d < -HALF_TURN) d = d + FULL_TURN;
      if (d > HALF_TURN)  d = d - FULL_TURN;
      return ANGLE_W'(d);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ptl_if.sv =====
// ----------------------------------------------------------------------------
// ptl_if
// Valid/ready channels for point requests and motion responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptl_req_if;
   import ptl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;

   modport source (output valid, func, point_x, point_y, input ready);
   modport sink   (input valid, func, point_x, point_y, output ready);
endinterface

interface ptl_rsp_if;
   import ptl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [DIFF_W-1:0]   step_dx;
   logic signed [DIFF_W-1:0]   step_dy;
   logic [LEN_W-1:0]           step_length;
   logic [HEAD_W-1:0]          heading;
   logic signed [HEAD_W-1:0]   turn;
   logic                       encircled;

   modport source (output valid, step_dx, step_dy, step_length, heading, turn, encircled,
                   input ready);
   modport sink   (input valid, step_dx, step_dy, step_length, heading, turn, encircled,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/ptl_ram.sv =====
// ----------------------------------------------------------------------------
// ptl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ptl_cordic.sv =====
// ----------------------------------------------------------------------------
// ptl_cordic
// Iterative vectoring CORDIC: angle of (x, y) in 1/64 degree, one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_cordic (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ptl_pkg::cordic_req_type req,
   output      ptl_pkg::cordic_rsp_type rsp
);
   import ptl_pkg::*;

   logic                        busy_ff;
   logic [STEP_W-1:0]           step_ff;
   logic signed [CORDIC_W-1:0]  x_ff, y_ff;
   logic signed [Z_W-1:0]       z_ff;
   logic signed [ANGLE_W-1:0]   angle_ff;

   logic signed [CORDIC_W-1:0]  xs, ys, x_step, y_step;
   logic signed [Z_W-1:0]       z_step, z_round;
   logic signed [CORDIC_W-1:0]  x_ext, y_ext;

   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      if (y_ff > 0) begin
         x_step = x_ff + ys;
         y_step = y_ff - xs;
         z_step = z_ff + Z_W'(ATAN_TAB[step_ff]);
      end else begin
         x_step = x_ff - ys;
         y_step = y_ff + xs;
         z_step = z_ff - Z_W'(ATAN_TAB[step_ff]);
      end
      z_round = (z_step + Z_W'(32)) >>> 6;
      x_ext   = CORDIC_W'(req.x);
      y_ext   = CORDIC_W'(req.y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req.start) begin
         // axis cases resolve at once
         if (req.y == '0) begin
            angle_ff <= (req.x < 0) ? ANGLE_W'(HALF_TURN) : '0;
            busy_ff  <= 1'b0;
         end else if (req.x == '0) begin
            angle_ff <= (req.y > 0) ? QUARTER_TURN : -QUARTER_TURN;
            busy_ff  <= 1'b0;
         end else begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            if (req.x < 0) begin
               z_ff <= (req.y > 0) ? Z_HALF_TURN : -Z_HALF_TURN;
               x_ff <= (-x_ext) <<< PRESCALE;
               y_ff <= (-y_ext) <<< PRESCALE;
            end else begin
               z_ff <= '0;
               x_ff <= x_ext <<< PRESCALE;
               y_ff <= y_ext <<< PRESCALE;
            end
         end
      end else if (busy_ff) begin
         x_ff    <= x_step;
         y_ff    <= y_step;
         z_ff    <= z_step;
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_ff  <= 1'b0;
            angle_ff <= ANGLE_W'(z_round);
         end
      end
   end

   assign rsp.busy  = busy_ff;
   assign rsp.angle = angle_ff;

endmodule

`default_nettype wire

// ===== rtl/pointer_trail_motion_and_loop_test_top.sv =====
// Append: load, two squares, a 22-step root with the 16-step CORDIC alongside, then commit;
// a first point, or a query on a trail of under three points, goes straight to the result.
// Query: the shared CORDIC and one trail RAM read for each stored point walked, newest first
// (a point equal to the query point skips the CORDIC), until a full turn or the whole trail.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Reset empties the trail at once (no clearing pass).
// ----------------------------------------------------------------------------
// pointer_trail_motion_and_loop_test_top
// Pointer trail ring with step motion report and angle-sum encircle query.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pointer_trail_motion_and_loop_test_top #(
   parameter int TRAIL_DEPTH = ptl_pkg::TRAIL_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ptl_req_if.sink    req_ch,
   ptl_rsp_if.source  rsp_ch
);
   import ptl_pkg::*;

   localparam int AW = $clog2(TRAIL_DEPTH);
   localparam int CW = $clog2(TRAIL_DEPTH + 1);
   localparam int RAM_W = 2 * COORD_W;

   state_type state_ff, state_in;

   // item and work registers
   logic                       func_ff;
   logic signed [COORD_W-1:0]  px_ff, py_ff;
   logic signed [DIFF_W-1:0]   dx_ff, dy_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [ROOT_W-1:0]          rem_ff, root_ff, bit_ff;
   logic [LEN_W-1:0]           len_ff;
   logic [HEAD_W-1:0]          head_ff;
   logic signed [HEAD_W-1:0]   turn_ff;
   logic                       enc_ff;
   logic [AW-1:0]              ptr_ff;
   logic [CW-1:0]              k_ff;
   logic signed [TOTAL_W-1:0]  total_ff;
   logic signed [ANGLE_W-1:0]  lastang_ff;

   // trail state
   logic [AW-1:0]              newest_ff;
   logic [CW-1:0]              count_ff;
   logic [HEAD_W-1:0]          last_head_ff;

   // output register
   logic                       rsp_valid_ff;
   logic signed [DIFF_W-1:0]   out_dx_ff, out_dy_ff;
   logic [LEN_W-1:0]           out_len_ff;
   logic [HEAD_W-1:0]          out_head_ff;
   logic signed [HEAD_W-1:0]   out_turn_ff;
   logic                       out_enc_ff;

   // control
   logic               req_take, rsp_load;
   logic               ram_rd_en, ram_wr_en;
   logic [AW-1:0]      ram_rd_addr, ram_wr_addr;
   logic [RAM_W-1:0]   ram_wr_data, ram_rd_data;
   cordic_req_type     cordic_req;
   cordic_rsp_type     cordic_rsp;

   // datapath helpers
   logic signed [COORD_W-1:0]  rd_x, rd_y;
   logic signed [DIFF_W-1:0]   dx_new, dy_new, qx, qy;
   logic signed [DIFF_W-1:0]   mul_op;
   logic signed [SQ_W-1:0]     prod;
   logic [SQ_W-1:0]            sq_sum;
   logic [ROOT_W-1:0]          trial;
   logic                       root_done, q_done, q_zero, out_free;
   logic [AW-1:0]              slot_inc, ptr_dec, commit_slot;
   logic signed [TOTAL_W-1:0]  ang_pos;
   logic [HEAD_W-1:0]          head_new;
   logic signed [ANGLE_W-1:0]  d_step;
   logic                       sign_flip;

   ptl_ram #(.WIDTH(RAM_W), .DEPTH(TRAIL_DEPTH)) u_trail (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptl_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   always_comb begin
      rd_x    = ram_rd_data[RAM_W-1:COORD_W];
      rd_y    = ram_rd_data[COORD_W-1:0];
      dx_new  = DIFF_W'(px_ff) - DIFF_W'(rd_x);
      dy_new  = DIFF_W'(py_ff) - DIFF_W'(rd_y);
      qx      = DIFF_W'(rd_x) - DIFF_W'(px_ff);
      qy      = DIFF_W'(rd_y) - DIFF_W'(py_ff);
      q_zero  = (qx == '0) && (qy == '0);
      mul_op  = (state_ff == ST_A_SQX) ? dx_ff : dy_ff;
      prod    = mul_op * mul_op;
      sq_sum  = sq_ff + SQ_W'(unsigned'(prod));
      trial   = root_ff + bit_ff;
      root_done = (bit_ff == '0) && !cordic_rsp.busy;
      q_done  = (k_ff == count_ff) || (total_ff >= FULL_TURN) || (total_ff <= -FULL_TURN);
      out_free = !rsp_valid_ff || rsp_ch.ready;
      slot_inc = (newest_ff == AW'(TRAIL_DEPTH - 1)) ? '0 : newest_ff + 1'b1;
      ptr_dec  = (ptr_ff == '0) ? AW'(TRAIL_DEPTH - 1) : ptr_ff - 1'b1;
      commit_slot = (count_ff == '0) ? '0 : slot_inc;
      // heading wraps negative angles into one full turn
      ang_pos = TOTAL_W'(cordic_rsp.angle);
      if (ang_pos < 0) ang_pos = ang_pos + FULL_TURN;
      head_new = ((dx_ff == '0) && (dy_ff == '0)) ? last_head_ff : HEAD_W'(ang_pos);
      d_step  = wrap_delta(lastang_ff, cordic_rsp.angle);
      sign_flip = ((d_step < 0) && (total_ff > 0)) || ((d_step > 0) && (total_ff < 0));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (!req_ch.func) begin
                  state_in = (count_ff == '0) ? ST_FINISH : ST_A_LOAD;
               end else begin
                  state_in = (count_ff < CW'(3)) ? ST_FINISH : ST_Q_FIRST;
               end
            end
         end
         ST_A_LOAD:  state_in = ST_A_SQX;
         ST_A_SQX:   state_in = ST_A_SQY;
         ST_A_SQY:   state_in = ST_A_ROOT;
         ST_A_ROOT:  if (root_done) state_in = ST_FINISH;
         ST_Q_FIRST: state_in = ST_Q_FWAIT;
         ST_Q_FWAIT: if (!cordic_rsp.busy) state_in = ST_Q_CHECK;
         ST_Q_CHECK: state_in = q_done ? ST_FINISH : ST_Q_LOAD;
         ST_Q_LOAD:  state_in = q_zero ? ST_Q_CHECK : ST_Q_WAIT;
         ST_Q_WAIT:  if (!cordic_rsp.busy) state_in = ST_Q_CHECK;
         ST_FINISH:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready     = 1'b0;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = ptr_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = commit_slot;
      ram_wr_data      = {px_ff, py_ff};
      cordic_req.start = 1'b0;
      cordic_req.x     = qx;
      cordic_req.y     = qy;
      rsp_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            ram_rd_en    = req_ch.valid;
            ram_rd_addr  = newest_ff;
         end
         ST_A_SQY: begin
            cordic_req.start = (dx_ff != '0) || (dy_ff != '0);
            cordic_req.x     = dx_ff;
            cordic_req.y     = -dy_ff;
         end
         ST_Q_FIRST: cordic_req.start = 1'b1;
         ST_Q_CHECK: ram_rd_en = !q_done;
         ST_Q_LOAD:  cordic_req.start = !q_zero;
         ST_FINISH: begin
            rsp_load  = out_free;
            ram_wr_en = out_free && !func_ff;
         end
         default: ;
      endcase
   end

   assign req_take = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         newest_ff    <= '0;
         count_ff     <= '0;
         last_head_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            newest_ff    <= commit_slot;
            last_head_ff <= head_ff;
            if (count_ff != CW'(TRAIL_DEPTH)) count_ff <= count_ff + 1'b1;
         end
      end
   end

   // work registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff  <= req_ch.func;
         px_ff    <= req_ch.point_x;
         py_ff    <= req_ch.point_y;
         dx_ff    <= '0;
         dy_ff    <= '0;
         len_ff   <= '0;
         head_ff  <= '0;
         turn_ff  <= '0;
         enc_ff   <= 1'b0;
         ptr_ff   <= newest_ff;
         k_ff     <= '0;
         total_ff <= '0;
      end
      unique case (state_ff)
         ST_A_LOAD: begin
            dx_ff <= dx_new;
            dy_ff <= dy_new;
         end
         ST_A_SQX: sq_ff <= SQ_W'(unsigned'(prod));
         ST_A_SQY: begin
            rem_ff  <= ROOT_W'({sq_sum, 8'b0});
            root_ff <= '0;
            bit_ff  <= ROOT_W'(1) << (ROOT_W - 1);
         end
         ST_A_ROOT: begin
            if (bit_ff != '0) begin
               if (rem_ff >= trial) begin
                  rem_ff  <= rem_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else if (root_done) begin
               // round half up on the remainder
               len_ff  <= LEN_W'(root_ff + ((rem_ff > root_ff) ? ROOT_W'(1) : '0));
               head_ff <= head_new;
               turn_ff <= HEAD_W'(wrap_delta(ANGLE_W'(last_head_ff), ANGLE_W'(head_new)));
            end
         end
         ST_Q_FWAIT: begin
            if (!cordic_rsp.busy) lastang_ff <= cordic_rsp.angle;
         end
         ST_Q_CHECK: begin
            if (q_done) enc_ff <= (total_ff >= FULL_TURN) || (total_ff <= -FULL_TURN);
         end
         ST_Q_LOAD: begin
            ptr_ff <= ptr_dec;
            k_ff   <= k_ff + 1'b1;
         end
         ST_Q_WAIT: begin
            if (!cordic_rsp.busy) begin
               // restart the sum when the turn direction flips
               total_ff   <= (sign_flip ? TOTAL_W'(0) : total_ff) + TOTAL_W'(d_step);
               lastang_ff <= cordic_rsp.angle;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         out_dx_ff   <= dx_ff;
         out_dy_ff   <= dy_ff;
         out_len_ff  <= len_ff;
         out_head_ff <= head_ff;
         out_turn_ff <= turn_ff;
         out_enc_ff  <= enc_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.step_dx     = out_dx_ff;
   assign rsp_ch.step_dy     = out_dy_ff;
   assign rsp_ch.step_length = out_len_ff;
   assign rsp_ch.heading     = out_head_ff;
   assign rsp_ch.turn        = out_turn_ff;
   assign rsp_ch.encircled   = out_enc_ff;

   `PTL_ASSERT_HOLD(a_count_range, clock, reset, count_ff <= CW'(TRAIL_DEPTH))
   `PTL_ASSERT_HOLD(a_newest_range, clock, reset, newest_ff <= AW'(TRAIL_DEPTH - 1))
   `PTL_ASSERT_IMPLY(a_cordic_free, clock, reset, cordic_req.start, !cordic_rsp.busy)
   `PTL_ASSERT_NEXT(a_finish_stall, clock, reset, (state_ff == ST_FINISH) && !out_free,
                    (state_ff == ST_FINISH))

endmodule

`default_nettype wire

// ===== sim/pointer_trail_motion_and_loop_test_top_test.sv =====
// ----------------------------------------------------------------------------
// pointer_trail_motion_and_loop_test_top_test
// Drives appends and encircle queries into the pointer trail block, predicts
// each motion and loop answer, and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_trail_motion_and_loop_test_top_test;
   import ptl_pkg::*;

   localparam int DEPTH     = 64;
   localparam int N_RANDOM  = 400;
   localparam int LIMIT     = 3000000;
   localparam bit OP_APPEND = 1'b0;
   localparam bit OP_QUERY  = 1'b1;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [LEN_W-1:0]         len;
      logic [HEAD_W-1:0]        head;
      logic signed [HEAD_W-1:0] turn;
      logic                     enc;
   } motion_type;

   typedef struct {
      bit                       func;
      logic signed [15:0]       x;
      logic signed [15:0]       y;
      bit                       typed;
      motion_type               want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptl_req_if req_ch ();
   ptl_rsp_if rsp_ch ();

   pointer_trail_motion_and_loop_test_top #(.TRAIL_DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // predictor state
   logic signed [15:0] ring_x [DEPTH];
   logic signed [15:0] ring_y [DEPTH];
   int unsigned        head_slot;
   int unsigned        n_points;
   int                 prev_heading;

   motion_type pending_q [$];
   int      mismatches = 0;
   int      cycles     = 0;
   bit      quiet      = 1'b0;
   bit      hold_long  = 1'b0;
   bit      hold_armed = 1'b0;

   localparam longint ATAN_T [16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667,
      1833, 917, 458, 229, 115, 57, 29, 14, 7};

   function automatic int cordic_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (y == 0) return x < 0 ? 11520 : 0;
      if (x == 0) return y > 0 ? 5760 : -5760;
      if (x < 0) begin
         z = (y > 0) ? 737280 : -737280;
         x = -x;
         y = -y;
      end
      x = x * 16384;
      y = y * 16384;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_T[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_T[i];
         end
      end
      return int'((z + 32) >>> 6);
   endfunction

   function automatic int wrap_step(int a1, int a2);
      int d;
      d = a2 - a1;
      if (d < -11520) d += 23040;
      if (d > 11520) d -= 23040;
      return d;
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic motion_type predict_motion(bit func, logic signed [15:0] px,
                                                 logic signed [15:0] py);
      motion_type res;
      longint dx, dy, qx, qy;
      longint unsigned n, m;
      int hd, tr, total, lastang, ang, d;
      int unsigned idx;
      res = '0;
      dx = 0; dy = 0; hd = 0; tr = 0;
      if (func == OP_APPEND) begin
         if (n_points > 0) begin
            dx = longint'(px) - ring_x[head_slot];
            dy = longint'(py) - ring_y[head_slot];
            n = longint'(dx * dx + dy * dy) * 256;
            m = int_root(n);
            if (n - m * m > m) m++;
            res.len = LEN_W'(m);
            if (dx != 0 || dy != 0) begin
               hd = cordic_angle(dx, -dy);
               if (hd < 0) hd += 23040;
            end else hd = prev_heading;
            tr = wrap_step(prev_heading, hd);
            head_slot = (head_slot + 1) % DEPTH;
         end else head_slot = 0;
         ring_x[head_slot] = px;
         ring_y[head_slot] = py;
         if (n_points < DEPTH) n_points++;
         prev_heading = hd;
      end else if (n_points >= 3) begin
         total = 0;
         lastang = cordic_angle(longint'(ring_x[head_slot]) - px,
                                longint'(ring_y[head_slot]) - py);
         for (int k = 0; k < n_points && total < 23040 && total > -23040; k++) begin
            idx = (head_slot + DEPTH - k) % DEPTH;
            qx = longint'(ring_x[idx]) - px;
            qy = longint'(ring_y[idx]) - py;
            if (qx == 0 && qy == 0) continue;
            ang = cordic_angle(qx, qy);
            d = wrap_step(lastang, ang);
            if ((d < 0 && total > 0) || (d > 0 && total < 0)) total = 0;
            total += d;
            lastang = ang;
         end
         res.enc = (total >= 23040 || total <= -23040);
      end
      res.dx = DIFF_W'(dx);
      res.dy = DIFF_W'(dy);
      res.head = HEAD_W'(hd);
      res.turn = HEAD_W'(tr);
      return res;
   endfunction

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response checker
   always @(posedge clock) begin
      motion_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.step_dx, rsp_ch.step_dy, rsp_ch.step_length, rsp_ch.heading,
                 rsp_ch.turn, rsp_ch.encircled};
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_ch.ready <= 1'b0;
            repeat (4000) @(negedge clock);
            hold_long = 1'b0;
         end
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // valid stays up between back-to-back items and drops for an idle burst and after the last item
   task automatic send_item(bit func, logic signed [15:0] px, logic signed [15:0] py,
                            bit typed, motion_type want);
      motion_type pred;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= func;
      req_ch.point_x <= px;
      req_ch.point_y <= py;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = predict_motion(func, px, py);
      pending_q = {pending_q, (typed ? want : pred)};
      if (typed && want !== pred) $display("directed row disagrees with predictor");
      @(negedge clock);
   endtask

   stim_row_type rows [$];

   function automatic stim_row_type row(bit f, int x, int y, bit t, motion_type w);
      stim_row_type r;
      r.func = f; r.x = 16'(x); r.y = 16'(y); r.typed = t; r.want = w;
      return r;
   endfunction

   initial begin
      int cx, cy, rad, npts, ang;
      motion_type z;
      z = '0;
      req_ch.valid = 1'b0;
      req_ch.func = OP_APPEND;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      head_slot = 0; n_points = 0; prev_heading = 0;

      // short trail queries, first point, extremes, zero step, square loop
      rows = {rows, row(OP_QUERY, 0, 0, 1, z)};
      rows = {rows, row(OP_APPEND, -32768, -32768, 1, z)};
      rows = {rows, row(OP_QUERY, 5, 5, 1, z)};
      rows = {rows, row(OP_APPEND, 32767, 32767, 0, z)};
      rows = {rows, row(OP_APPEND, 32767, 32767, 0, z)};
      rows = {rows, row(OP_APPEND, -32768, 32767, 0, z)};
      rows = {rows, row(OP_APPEND, 32767, -32768, 0, z)};
      rows = {rows, row(OP_APPEND, 10, 0, 0, z)};
      rows = {rows, row(OP_APPEND, 0, 10, 0, z)};
      rows = {rows, row(OP_APPEND, -10, 0, 0, z)};
      rows = {rows, row(OP_APPEND, 0, -10, 0, z)};
      rows = {rows, row(OP_APPEND, 10, 0, 0, z)};
      rows = {rows, row(OP_QUERY, 0, 0, 0, z)};
      rows = {rows, row(OP_QUERY, 10, 0, 0, z)};
      rows = {rows, row(OP_QUERY, 100, 100, 0, z)};
      rows = {rows, row(OP_QUERY, -32768, 32767, 0, z)};

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send_item(rows[i].func, rows[i].x, rows[i].y, rows[i].typed,
                                  rows[i].want);

      for (int n = 0; n < N_RANDOM; ) begin
         if (n >= 100 && !hold_armed) begin
            hold_armed = 1'b1;
            hold_long  = 1'b1;
         end
         if (n >= N_RANDOM - 60) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // loop of points around a center, then queries
               cx = $urandom_range(0, 65535) - 32768;
               cy = $urandom_range(0, 65535) - 32768;
               rad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32767)
                                                 : $urandom_range(1, 200);
               npts = $urandom_range(3, 12);
               for (int k = 0; k <= npts; k++) begin
                  ang = $urandom_range(0, 3) - 1;
                  cx = cx; // center kept
                  send_item(OP_APPEND,
                            16'(cx + ((k % 4 == 0) ? rad : (k % 4 == 2) ? -rad : ang)),
                            16'(cy + ((k % 4 == 1) ? rad : (k % 4 == 3) ? -rad : ang)),
                            0, z);
                  n++;
               end
               send_item(OP_QUERY, 16'(cx), 16'(cy), 0, z);
               send_item(OP_QUERY, 16'(cx + $urandom_range(0, 2 * rad) - rad),
                         16'(cy + $urandom_range(0, 2 * rad) - rad), 0, z);
               n += 2;
            end
            6, 7: begin
               send_item(OP_APPEND, 16'($urandom), 16'($urandom), 0, z);
               n++;
            end
            default: begin
               send_item($urandom_range(0, 1), 16'($urandom), 16'($urandom), 0, z);
               n++;
            end
         endcase
      end
      req_ch.valid <= 1'b0;

      wait (pending_q.size() == 0);
      repeat (1400) @(posedge clock);
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
